>>> sv/market_probability_estimator_unit_defines.svh
// Assertion macros used by the checker of the probability estimator.
`ifndef MARKET_PROBABILITY_ESTIMATOR_UNIT_DEFINES_SVH
`define MARKET_PROBABILITY_ESTIMATOR_UNIT_DEFINES_SVH

// ante implies cons, checked at every rising edge outside reset
`define MPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpe checker: implication violated");

// expr holds at every rising edge outside reset
`define MPE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("mpe checker: invariant violated");

`endif

>>> sv/mpe_pkg.sv
// Package of the probability estimator: codes, constants and the sigmoid table.
package mpe_pkg;

  localparam int unsigned MPE_PRICE_SCALE_DEF = 10000;
  localparam int unsigned MPE_LATENCY         = 8;
  localparam int unsigned MPE_LUT_DEPTH       = 256;

  localparam logic [16:0]        MPE_ONE_Q16  = 17'd65536;
  localparam logic [13:0]        MPE_CAP_Q16  = 14'd9830;
  localparam logic signed [14:0] MPE_CAP_S    = 15'sd9830;
  localparam logic signed [32:0] MPE_MID_HALF = 33'sd32768;

  // floor(2^34 / 100) and floor(2^30 / 225)
  localparam logic [27:0] MPE_VEL_RECIP = 28'd171798691;
  localparam logic [22:0] MPE_TTE_RECIP = 23'd4772185;

  // exp(-1/16) in Q0.32
  localparam logic [63:0] MPE_EXP_STEP_Q32 = 64'd4034748382;

  typedef enum logic [1:0] {
    MODE_HEURISTIC = 2'd0,
    MODE_LOGISTIC  = 2'd1,
    MODE_EMPIRICAL = 2'd2
  } mpe_mode_t;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_BIAS_W      = 3'd1,
    REG_RET_SHORT_W = 3'd2,
    REG_RET_LONG_W  = 3'd3,
    REG_IMBALANCE_W = 3'd4,
    REG_VELOCITY_W  = 3'd5,
    REG_EXPIRY_W    = 3'd6
  } mpe_reg_t;

  typedef logic [16:0] mpe_lut_t [MPE_LUT_DEPTH];

  // Elaboration-time build of the sigmoid table; quotient by bitwise long division.
  function automatic mpe_lut_t mpe_build_lut();
    mpe_lut_t    lut;
    logic [63:0] e_tab [129];
    logic [63:0] e;
    logic [63:0] p;
    logic [33:0] den;
    logic [48:0] num;
    logic [34:0] rem;
    logic [16:0] s;
    int          i;
    int          k;
    int          b;
    e = 64'd1 << 32;
    for (k = 0; k <= 128; k++) begin
      e_tab[k] = e;
      p = e * MPE_EXP_STEP_Q32;
      e = (p + (64'd1 << 31)) >> 32;
    end
    for (i = 0; i < MPE_LUT_DEPTH; i++) begin
      k   = (i >= 128) ? (i - 128) : (128 - i);
      den = 34'((64'd1 << 32) + e_tab[k]);
      num = (49'd1 << 48) + 49'(den >> 1);
      rem = '0;
      s   = '0;
      for (b = 48; b >= 0; b--) begin
        rem = {rem[33:0], num[b]};
        if (rem >= {1'b0, den}) begin
          rem = rem - {1'b0, den};
          if (b < 17) begin
            s[b] = 1'b1;
          end
        end
      end
      lut[i] = (i >= 128) ? s : 17'(MPE_ONE_Q16 - s);
    end
    return lut;
  endfunction

  localparam mpe_lut_t MPE_SIG_LUT = mpe_build_lut();

endpackage

>>> sv/market_probability_estimator_unit.sv
// Top level of the market probability estimator: eight-stage inference pipeline.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  input    | start / busy           | in_bid_price .. in_seconds_to_expiry
//  result   | out_valid (strobe)     | out_probability, Q1.16 in 0..65536
//  config   | cfg_valid / cfg_ready  | cfg_index (register number), cfg_data
//
// One beat enters per cycle; busy stays low, every start is taken.
// Each beat is registered through stage registers s1 to s7 and prob_r, its valid
// bit through vld_r. The depth is set by the reciprocal divisions (multiply,
// back-multiply, correct), the weight multipliers, a three-level adder tree and
// the table read. Synchronous reset clears the valid chain and the configuration
// registers; data registers are not reset, their contents are don't-care while
// the matching valid bit is low.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module market_probability_estimator_unit #(
  parameter int unsigned PRICE_SCALE = mpe_pkg::MPE_PRICE_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [13:0]        in_bid_price,
  input  logic [13:0]        in_ask_price,
  input  logic signed [31:0] in_return_short,
  input  logic signed [31:0] in_return_long,
  input  logic signed [17:0] in_book_imbalance,
  input  logic signed [31:0] in_price_velocity,
  input  logic [15:0]        in_seconds_to_expiry,
  output logic               out_valid,
  output logic [16:0]        out_probability,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import mpe_pkg::*;

  // mid = round((bid+ask)*65536 / (2*PRICE_SCALE)): reciprocal estimate, one fixup
  localparam logic [16:0] MID_DIV = 17'(2 * PRICE_SCALE);
  localparam logic [31:0] MID_M   = 32'((64'd1 << 32) / (2 * PRICE_SCALE));

  // ---------------- configuration registers ----------------
  logic [1:0]         mode_r;
  logic signed [31:0] bias_w_r, rs_w_r, rl_w_r, imb_w_r, vel_w_r, exp_w_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_HEURISTIC;
      bias_w_r <= '0;
      rs_w_r   <= '0;
      rl_w_r   <= '0;
      imb_w_r  <= '0;
      vel_w_r  <= '0;
      exp_w_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:        mode_r   <= cfg_data[1:0];
        REG_BIAS_W:      bias_w_r <= $signed(cfg_data);
        REG_RET_SHORT_W: rs_w_r   <= $signed(cfg_data);
        REG_RET_LONG_W:  rl_w_r   <= $signed(cfg_data);
        REG_IMBALANCE_W: imb_w_r  <= $signed(cfg_data);
        REG_VELOCITY_W:  vel_w_r  <= $signed(cfg_data);
        REG_EXPIRY_W:    exp_w_r  <= $signed(cfg_data);
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------- valid chain ----------------
  logic                   accept;
  logic [MPE_LATENCY-1:0] vld_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[MPE_LATENCY-2:0], accept};
    end
  end

  assign out_valid = vld_r[MPE_LATENCY-1];

  // ---------------- stage 1: feature scaling, heuristic/empirical terms ----------------
  logic signed [38:0] rs_x100, rl_x100;
  logic signed [36:0] rs_x25;
  logic signed [28:0] dh_full;
  logic signed [14:0] dh_clip;
  logic [31:0]        rs_mag;
  logic [36:0]        mag_x25;
  logic [28:0]        m_full;
  logic [13:0]        m_clip;
  logic signed [17:0] emp_scale;
  logic [31:0]        vel_adj;

  always_comb begin
    rs_x100 = 39'(in_return_short) * 39'sd100;
    rl_x100 = 39'(in_return_long) * 39'sd100;
    rs_x25  = 37'(in_return_short) * 37'sd25;
    dh_full = rs_x25[36:8];
    if (dh_full > 29'(MPE_CAP_S)) begin
      dh_clip = MPE_CAP_S;
    end else if (dh_full < -29'(MPE_CAP_S)) begin
      dh_clip = -MPE_CAP_S;
    end else begin
      dh_clip = dh_full[14:0];
    end
    rs_mag  = in_return_short[31] ? (~$unsigned(in_return_short) + 32'd1)
                                  : $unsigned(in_return_short);
    mag_x25 = 37'(rs_mag) * 37'd25;
    m_full  = mag_x25[36:8];
    m_clip  = (m_full > 29'(MPE_CAP_Q16)) ? MPE_CAP_Q16 : m_full[13:0];
    // 1 + imbalance/2, always in 0..131071
    emp_scale = 18'sd65536 + (in_book_imbalance >>> 1);
    // floor(v/100) for v < 0 is -((-v + 99) / 100)
    vel_adj = in_price_velocity[31] ? (~$unsigned(in_price_velocity) + 32'd100)
                                    : $unsigned(in_price_velocity);
  end

  logic [14:0]        s1_sum_r;
  logic               s1_both_r;
  logic signed [30:0] s1_f1_r, s1_f2_r;
  logic signed [17:0] s1_imb_r;
  logic [31:0]        s1_vabs_r;
  logic               s1_vneg_r;
  logic [15:0]        s1_tte_r;
  logic signed [14:0] s1_dh_r;
  logic [13:0]        s1_m_r;
  logic [16:0]        s1_f_r;
  logic               s1_rpos_r, s1_rneg_r;

  always_ff @(posedge clk) begin
    s1_sum_r  <= 15'(in_bid_price) + 15'(in_ask_price);
    s1_both_r <= (in_bid_price != '0) && (in_ask_price != '0);
    s1_f1_r   <= rs_x100[38:8];
    s1_f2_r   <= rl_x100[38:8];
    s1_imb_r  <= in_book_imbalance;
    s1_vabs_r <= vel_adj;
    s1_vneg_r <= in_price_velocity[31];
    s1_tte_r  <= in_seconds_to_expiry;
    s1_dh_r   <= dh_clip;
    s1_m_r    <= m_clip;
    s1_f_r    <= emp_scale[16:0];
    s1_rpos_r <= !in_return_short[31] && (in_return_short != '0);
    s1_rneg_r <= in_return_short[31];
  end

  // ---------------- stage 2: first multiplier row ----------------
  logic signed [62:0] prod1, prod2;
  logic signed [49:0] prod3;
  logic [30:0]        emp_prod;

  always_comb begin
    prod1    = $signed(rs_w_r) * $signed(s1_f1_r);
    prod2    = $signed(rl_w_r) * $signed(s1_f2_r);
    prod3    = $signed(imb_w_r) * $signed(s1_imb_r);
    emp_prod = 31'(s1_m_r) * 31'(s1_f_r);
  end

  logic [46:0]        s2_pm_r;
  logic [31:0]        s2_n_r;
  logic signed [46:0] s2_p1_r, s2_p2_r;
  logic signed [33:0] s2_p3_r;
  logic [59:0]        s2_pv_r;
  logic [38:0]        s2_pt_r;
  logic [14:0]        s2_de_r;
  logic               s2_both_r, s2_vneg_r, s2_rpos_r, s2_rneg_r;
  logic [31:0]        s2_vabs_r;
  logic [15:0]        s2_tte_r;
  logic signed [14:0] s2_dh_r;

  always_ff @(posedge clk) begin
    s2_pm_r   <= 47'(s1_sum_r) * 47'(MID_M);
    s2_n_r    <= {1'b0, s1_sum_r, 16'h0000} + 32'(PRICE_SCALE);
    s2_p1_r   <= prod1[62:16];
    s2_p2_r   <= prod2[62:16];
    s2_p3_r   <= prod3[49:16];
    s2_pv_r   <= 60'(s1_vabs_r) * 60'(MPE_VEL_RECIP);
    s2_pt_r   <= 39'(s1_tte_r) * 39'(MPE_TTE_RECIP);
    s2_de_r   <= emp_prod[30:16];
    s2_both_r <= s1_both_r;
    s2_vneg_r <= s1_vneg_r;
    s2_rpos_r <= s1_rpos_r;
    s2_rneg_r <= s1_rneg_r;
    s2_vabs_r <= s1_vabs_r;
    s2_tte_r  <= s1_tte_r;
    s2_dh_r   <= s1_dh_r;
  end

  // ---------------- stage 3: quotient estimates and back-multiply ----------------
  logic [30:0] s3_qm_r;
  logic [31:0] s3_tm_r, s3_n_r;
  logic [25:0] s3_qv_r;
  logic [31:0] s3_tv_r;
  logic [22:0] s3_qt_r;
  logic [29:0] s3_tt_r;
  logic signed [46:0] s3_p1_r, s3_p2_r;
  logic signed [33:0] s3_p3_r;
  logic [14:0]        s3_de_r;
  logic               s3_both_r, s3_vneg_r, s3_rpos_r, s3_rneg_r;
  logic [31:0]        s3_vabs_r;
  logic [15:0]        s3_tte_r;
  logic signed [14:0] s3_dh_r;

  always_ff @(posedge clk) begin
    s3_qm_r   <= s2_pm_r[46:16];
    s3_tm_r   <= 32'(48'(s2_pm_r[46:16]) * 48'(MID_DIV));
    s3_n_r    <= s2_n_r;
    s3_qv_r   <= s2_pv_r[59:34];
    s3_tv_r   <= 32'(34'(s2_pv_r[59:34]) * 34'd100);
    s3_qt_r   <= s2_pt_r[38:16];
    s3_tt_r   <= 30'(31'(s2_pt_r[38:16]) * 31'd225);
    s3_p1_r   <= s2_p1_r;
    s3_p2_r   <= s2_p2_r;
    s3_p3_r   <= s2_p3_r;
    s3_de_r   <= s2_de_r;
    s3_both_r <= s2_both_r;
    s3_vneg_r <= s2_vneg_r;
    s3_rpos_r <= s2_rpos_r;
    s3_rneg_r <= s2_rneg_r;
    s3_vabs_r <= s2_vabs_r;
    s3_tte_r  <= s2_tte_r;
    s3_dh_r   <= s2_dh_r;
  end

  // ---------------- stage 4: remainder fixups ----------------
  logic [31:0]        mid_rem;
  logic [31:0]        mid_q;
  logic [31:0]        vel_rem;
  logic [25:0]        vel_q;
  logic [29:0]        tte_rem;

  always_comb begin
    mid_rem = s3_n_r - s3_tm_r;
    mid_q   = 32'(s3_qm_r) + ((mid_rem >= 32'(MID_DIV)) ? 32'd1 : 32'd0);
    vel_rem = s3_vabs_r - s3_tv_r;
    vel_q   = s3_qv_r + ((vel_rem >= 32'd100) ? 26'd1 : 26'd0);
    tte_rem = {s3_tte_r, 14'h0000} - s3_tt_r;
  end

  logic [31:0]        s4_mid_r;
  logic signed [26:0] s4_f4_r;
  logic [22:0]        s4_f5_r;
  logic signed [46:0] s4_p1_r, s4_p2_r;
  logic signed [33:0] s4_p3_r;
  logic [14:0]        s4_de_r;
  logic               s4_both_r, s4_rpos_r, s4_rneg_r;
  logic signed [14:0] s4_dh_r;

  always_ff @(posedge clk) begin
    s4_mid_r  <= mid_q;
    s4_f4_r   <= s3_vneg_r ? -$signed({1'b0, vel_q}) : $signed({1'b0, vel_q});
    s4_f5_r   <= s3_qt_r + ((tte_rem >= 30'd225) ? 23'd1 : 23'd0);
    s4_p1_r   <= s3_p1_r;
    s4_p2_r   <= s3_p2_r;
    s4_p3_r   <= s3_p3_r;
    s4_de_r   <= s3_de_r;
    s4_both_r <= s3_both_r;
    s4_rpos_r <= s3_rpos_r;
    s4_rneg_r <= s3_rneg_r;
    s4_dh_r   <= s3_dh_r;
  end

  // ---------------- stage 5: second multiplier row, first adds ----------------
  logic signed [58:0] prod4;
  logic signed [55:0] prod5;
  logic signed [32:0] mid_sel;
  logic signed [15:0] d_sel;

  always_comb begin
    prod4   = $signed(vel_w_r) * $signed(s4_f4_r);
    prod5   = $signed(exp_w_r) * $signed({1'b0, s4_f5_r});
    mid_sel = s4_both_r ? $signed({1'b0, s4_mid_r}) : MPE_MID_HALF;
    if (mode_r == MODE_EMPIRICAL) begin
      if (s4_rpos_r) begin
        d_sel = $signed({1'b0, s4_de_r});
      end else if (s4_rneg_r) begin
        d_sel = -$signed({1'b0, s4_de_r});
      end else begin
        d_sel = '0;
      end
    end else begin
      d_sel = 16'(s4_dh_r);
    end
  end

  logic signed [42:0] s5_p4_r;
  logic signed [39:0] s5_p5_r;
  logic signed [49:0] s5_sa_r, s5_sb_r;
  logic signed [33:0] s5_nl_r;

  always_ff @(posedge clk) begin
    s5_p4_r <= prod4[58:16];
    s5_p5_r <= prod5[55:16];
    s5_sa_r <= 50'(bias_w_r) + 50'(s4_p1_r);
    s5_sb_r <= 50'(s4_p2_r) + 50'(s4_p3_r);
    s5_nl_r <= 34'(mid_sel) + 34'(d_sel);
  end

  // ---------------- stage 6: adder tree, clamp of the direct modes ----------------
  logic signed [49:0] s6_sc_r, s6_sd_r;
  logic [16:0]        s6_nl_r;

  always_ff @(posedge clk) begin
    s6_sc_r <= s5_sa_r + s5_sb_r;
    s6_sd_r <= 50'(s5_p4_r) + 50'(s5_p5_r);
    if (s5_nl_r < 34'sd0) begin
      s6_nl_r <= '0;
    end else if (s5_nl_r > 34'(MPE_ONE_Q16)) begin
      s6_nl_r <= MPE_ONE_Q16;
    end else begin
      s6_nl_r <= s5_nl_r[16:0];
    end
  end

  // ---------------- stage 7: logit z in Q16 ----------------
  logic signed [49:0] s7_z_r;
  logic [16:0]        s7_nl_r;

  always_ff @(posedge clk) begin
    s7_z_r  <= s6_sc_r + s6_sd_r;
    s7_nl_r <= s6_nl_r;
  end

  // ---------------- stage 8: sigmoid read, mode select ----------------
  // z in [-8,8) iff bits 49..19 are all sign; index = (z + 2^19) >> 12
  logic       z_in_span;
  logic [7:0] lut_idx;
  logic [16:0] prob_nxt;

  always_comb begin
    z_in_span = (s7_z_r[49:19] == '0) || (s7_z_r[49:19] == '1);
    lut_idx   = {~s7_z_r[19], s7_z_r[18:12]};
    if (mode_r == MODE_LOGISTIC) begin
      if (z_in_span) begin
        prob_nxt = MPE_SIG_LUT[lut_idx];
      end else if (s7_z_r[49]) begin
        prob_nxt = '0;
      end else begin
        prob_nxt = MPE_ONE_Q16;
      end
    end else begin
      prob_nxt = s7_nl_r;
    end
  end

  logic [16:0] prob_r;

  always_ff @(posedge clk) begin
    prob_r <= prob_nxt;
  end

  assign out_probability = prob_r;

endmodule

>>> sv/mpe_checker.sv
// Port-level checker of the probability estimator and its bind.
`include "market_probability_estimator_unit_defines.svh"

module mpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [16:0] out_probability
);
  import mpe_pkg::*;

  // every accepted beat yields exactly one strobe, and each strobe comes from an accepted beat
  `MPE_ASSERT_IMP(a_beat_gives_result, clk, rst_n, start && !busy, ##MPE_LATENCY out_valid)
  `MPE_ASSERT_IMP(a_result_has_beat, clk, rst_n, out_valid, $past(start && !busy, MPE_LATENCY))
  // probability stays within 0..1
  `MPE_ASSERT_ALWAYS(a_prob_range, clk, rst_n, !out_valid || (out_probability <= MPE_ONE_Q16))

endmodule

bind market_probability_estimator_unit mpe_checker u_mpe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_probability (out_probability)
);
